### design/decc_pkg.sv
package decc_pkg;

	// One input beat: an expression character or the end mark.
	typedef struct packed {
		logic       kind;
		logic [7:0] character;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [2:0]         status;
		logic signed [63:0] first_operand;
		logic [7:0]         operator_char;
		logic signed [63:0] second_operand;
		logic signed [63:0] result_value;
	} result_t;

	// Signed operands and operator as parsed, handed to the arithmetic unit.
	typedef struct packed {
		logic signed [63:0] first_operand;
		logic [7:0]         operator_char;
		logic signed [63:0] second_operand;
	} operands_t;

	// Status of the arithmetic unit toward the top level.
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [2:0]  status;
		logic [63:0] value;
	} alu_stat_t;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [2:0] ST_VALUE = 3'd0;
	localparam logic [2:0] ST_OK    = 3'd1;
	localparam logic [2:0] ST_DIV0  = 3'd2;
	localparam logic [2:0] ST_MOD0  = 3'd3;
	localparam logic [2:0] ST_BADOP = 3'd4;

	localparam logic [7:0] CH_NONE  = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

### design/decimal_expression_calculator.sv
// Channel  | Direction | Handshake                   | Beat payload
// item     | in        | item_valid / item_stall     | decc_pkg::item_t (kind, character)
// result   | out       | result_valid / result_stall | decc_pkg::result_t
//
// A character beat is taken in the cycle it is offered while the unit is idle, so
// characters may run back to back. The edge that takes an end beat loads the shared
// arithmetic unit and settles value-only, add, subtract and error cases; multiply then
// runs its shift-add loop, divide and modulo 64 restoring steps and then a sign fix. The
// answer is registered to the output once the unit is done and the output is free;
// item_stall is high from the end beat until then. Reset clears the parser, the unit and result_valid.
module decimal_expression_calculator #(
	parameter int MAX_CHARS = 126
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  decc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output decc_pkg::result_t result
);

	decc_pkg::operands_t opnd;
	decc_pkg::operands_t opnd_q;
	decc_pkg::alu_stat_t stat;
	decc_pkg::result_t   res_next;
	decc_pkg::result_t   result_q;
	logic                result_valid_q;

	logic item_take;
	logic end_take;
	logic char_take;
	logic out_free;
	logic load_out;

	// The parser keeps running as long as the arithmetic unit is idle.
	assign item_stall = stat.busy;
	assign item_take  = item_valid && !item_stall;
	assign end_take   = item_take && (item.kind == decc_pkg::KIND_END);
	assign char_take  = item_take && (item.kind == decc_pkg::KIND_CHAR);

	assign out_free = !result_valid_q || !result_stall;
	assign load_out = stat.done && out_free;

	decc_parse #(
		.MAX_CHARS(MAX_CHARS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_en   (char_take),
		.character (item.character),
		.clear     (end_take),
		.opnd      (opnd)
	);

	decc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (end_take),
		.opnd   (opnd),
		.take   (load_out),
		.stat   (stat)
	);

	decc_fmt u_fmt (
		.opnd (opnd_q),
		.stat (stat),
		.res  (res_next)
	);

	// The operands stay in place for the result beat while the parser starts over.
	always_ff @(posedge clk) begin
		if (end_take) begin
			opnd_q <= opnd;
		end
		if (load_out) begin
			result_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		end_take |=> item_stall)
		else $error("end beat did not start the arithmetic unit");
	a_value_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.status == decc_pkg::ST_VALUE)
		== (result.operator_char == decc_pkg::CH_NONE)))
		else $error("value-only status does not match a missing operator");
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == decc_pkg::ST_DIV0
		|| result.status == decc_pkg::ST_MOD0)
		|-> (result.second_operand == 64'sd0) && (result.result_value == 64'sd0))
		else $error("zero-divisor status with a nonzero divisor or result");
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(stat.done))
		else $error("result beat appeared without a finished computation");
`endif

endmodule

### design/decc_parse.sv
module decc_parse #(
	parameter int MAX_CHARS = 126
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_en,
	input  logic [7:0]            character,
	input  logic                  clear,
	output decc_pkg::operands_t   opnd
);

	localparam int CNT_W = $clog2(MAX_CHARS + 1);

	typedef enum logic [4:0] {
		PH_FIRST_START  = 5'b00001,
		PH_FIRST_DIGITS = 5'b00010,
		PH_SECOND_START = 5'b00100,
		PH_SECOND_DIGITS = 5'b01000,
		PH_DONE         = 5'b10000
	} phase_t;

	phase_t             phase_q;
	logic [63:0]        first_mag_q;
	logic               first_neg_q;
	logic [7:0]         op_q;
	logic [63:0]        second_mag_q;
	logic               second_neg_q;
	logic [CNT_W-1:0]   chars_q;

	logic               is_digit;
	logic [63:0]        digit;
	logic               take;
	logic [63:0]        first_acc;
	logic [63:0]        second_acc;
	logic               has_op;

	assign is_digit = (character >= decc_pkg::CH_ZERO) && (character <= decc_pkg::CH_NINE);
	assign digit    = {56'd0, character - decc_pkg::CH_ZERO};
	assign take     = char_en && (character != decc_pkg::CH_NONE)
		&& (chars_q < CNT_W'(MAX_CHARS));

	// Times ten as two shifts and an add; digits wrap modulo 2^64.
	assign first_acc  = (first_mag_q << 3) + (first_mag_q << 1) + digit;
	assign second_acc = (second_mag_q << 3) + (second_mag_q << 1) + digit;

	assign has_op = (op_q != decc_pkg::CH_NONE);
	assign opnd.first_operand  = first_neg_q ? -first_mag_q : first_mag_q;
	assign opnd.operator_char  = op_q;
	assign opnd.second_operand = !has_op ? 64'sd0
		: (second_neg_q ? -second_mag_q : second_mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST_START;
			first_mag_q  <= '0;
			first_neg_q  <= 1'b0;
			op_q         <= decc_pkg::CH_NONE;
			second_mag_q <= '0;
			second_neg_q <= 1'b0;
			chars_q      <= '0;
		end else if (clear) begin
			phase_q      <= PH_FIRST_START;
			first_mag_q  <= '0;
			first_neg_q  <= 1'b0;
			op_q         <= decc_pkg::CH_NONE;
			second_mag_q <= '0;
			second_neg_q <= 1'b0;
			chars_q      <= '0;
		end else if (take) begin
			chars_q <= chars_q + CNT_W'(1);
			unique case (phase_q)
				PH_FIRST_START: begin
					if (character == decc_pkg::CH_MINUS) begin
						first_neg_q <= 1'b1;
						phase_q     <= PH_FIRST_DIGITS;
					end else if (character == decc_pkg::CH_PLUS) begin
						phase_q <= PH_FIRST_DIGITS;
					end else if (is_digit) begin
						first_mag_q <= digit;
						phase_q     <= PH_FIRST_DIGITS;
					end else begin
						op_q    <= character;
						phase_q <= PH_SECOND_START;
					end
				end
				PH_FIRST_DIGITS: begin
					if (is_digit) begin
						first_mag_q <= first_acc;
					end else begin
						op_q    <= character;
						phase_q <= PH_SECOND_START;
					end
				end
				PH_SECOND_START: begin
					if (character == decc_pkg::CH_MINUS) begin
						second_neg_q <= 1'b1;
						phase_q      <= PH_SECOND_DIGITS;
					end else if (character == decc_pkg::CH_PLUS) begin
						phase_q <= PH_SECOND_DIGITS;
					end else if (is_digit) begin
						second_mag_q <= digit;
						phase_q      <= PH_SECOND_DIGITS;
					end else begin
						phase_q <= PH_DONE;
					end
				end
				PH_SECOND_DIGITS: begin
					if (is_digit) begin
						second_mag_q <= second_acc;
					end else begin
						phase_q <= PH_DONE;
					end
				end
				PH_DONE: begin
					phase_q <= PH_DONE;
				end
				default: begin
					phase_q <= PH_DONE;
				end
			endcase
		end
	end

endmodule

### design/decc_alu.sv
module decc_alu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  decc_pkg::operands_t   opnd,
	input  logic                  take,
	output decc_pkg::alu_stat_t   stat
);

	typedef enum logic [4:0] {
		AL_IDLE = 5'b00001,
		AL_MUL  = 5'b00010,
		AL_DIV  = 5'b00100,
		AL_FIX  = 5'b01000,
		AL_DONE = 5'b10000
	} al_state_t;

	al_state_t   state_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic        neg_q;
	logic        rem_sel_q;
	logic [2:0]  status_q;
	logic [63:0] value_q;

	logic [63:0] a_u;
	logic [63:0] b_u;
	logic [63:0] a_mag;
	logic [63:0] b_mag;
	logic [64:0] trial;
	logic [63:0] mul_sum;
	logic [63:0] fix_val;
	logic [63:0] fix_res;
	logic        last;

	assign a_u   = opnd.first_operand;
	assign b_u   = opnd.second_operand;
	assign a_mag = a_u[63] ? -a_u : a_u;
	assign b_mag = b_u[63] ? -b_u : b_u;

	// Restoring division step: shift in the next dividend bit and try the divisor.
	assign trial   = {acc_q, x_q[63]} - {1'b0, y_q};
	assign mul_sum = y_q[0] ? acc_q + x_q : acc_q;
	assign fix_val = rem_sel_q ? acc_q : x_q;
	assign fix_res = neg_q ? -fix_val : fix_val;
	assign last    = (cnt_q == 6'd63);

	assign stat.busy   = (state_q != AL_IDLE);
	assign stat.done   = (state_q == AL_DONE);
	assign stat.status = status_q;
	assign stat.value  = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AL_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				AL_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						unique case (opnd.operator_char) inside
							decc_pkg::CH_STAR, decc_pkg::CH_X: state_q <= AL_MUL;
							decc_pkg::CH_SLASH, decc_pkg::CH_PCT: begin
								state_q <= (b_u == 64'd0) ? AL_DONE : AL_DIV;
							end
							default: state_q <= AL_DONE;
						endcase
					end
				end
				AL_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (last) begin
						state_q <= AL_DONE;
					end
				end
				AL_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (last) begin
						state_q <= AL_FIX;
					end
				end
				AL_FIX: state_q <= AL_DONE;
				AL_DONE: begin
					if (take) begin
						state_q <= AL_IDLE;
					end
				end
				default: state_q <= AL_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			AL_IDLE: begin
				if (start) begin
					acc_q     <= '0;
					status_q  <= decc_pkg::ST_OK;
					value_q   <= '0;
					rem_sel_q <= 1'b0;
					neg_q     <= 1'b0;
					x_q       <= a_mag;
					y_q       <= b_mag;
					unique case (opnd.operator_char) inside
						decc_pkg::CH_NONE: begin
							status_q <= decc_pkg::ST_VALUE;
							value_q  <= a_u;
						end
						decc_pkg::CH_PLUS:  value_q <= a_u + b_u;
						decc_pkg::CH_MINUS: value_q <= a_u - b_u;
						decc_pkg::CH_STAR, decc_pkg::CH_X: begin
							x_q <= a_u;
							y_q <= b_u;
						end
						decc_pkg::CH_SLASH: begin
							neg_q <= a_u[63] ^ b_u[63];
							if (b_u == 64'd0) begin
								status_q <= decc_pkg::ST_DIV0;
							end
						end
						decc_pkg::CH_PCT: begin
							neg_q     <= a_u[63];
							rem_sel_q <= 1'b1;
							if (b_u == 64'd0) begin
								status_q <= decc_pkg::ST_MOD0;
							end
						end
						default: status_q <= decc_pkg::ST_BADOP;
					endcase
				end
			end
			AL_MUL: begin
				// Shift-add keeps the low 64 product bits, which wrap correctly for signed values.
				acc_q <= mul_sum;
				x_q   <= x_q << 1;
				y_q   <= y_q >> 1;
				if (last) begin
					value_q <= mul_sum;
				end
			end
			AL_DIV: begin
				if (!trial[64]) begin
					acc_q <= trial[63:0];
					x_q   <= {x_q[62:0], 1'b1};
				end else begin
					acc_q <= {acc_q[62:0], x_q[63]};
					x_q   <= {x_q[62:0], 1'b0};
				end
			end
			AL_FIX: value_q <= fix_res;
			AL_DONE: value_q <= value_q;
			default: value_q <= value_q;
		endcase
	end

`ifndef ASSERT_OFF
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == AL_DIV) && last |=> (state_q == AL_FIX))
		else $error("division did not finish after 64 steps");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == AL_DONE) && !take |=> (state_q == AL_DONE) && $stable(value_q))
		else $error("finished result changed before it was taken");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == AL_FIX) |=> (state_q == AL_DONE))
		else $error("sign fix did not lead to done");
`endif

endmodule

### design/decc_top_dummy_unused.sv
module decc_fmt (
	input  decc_pkg::operands_t opnd,
	input  decc_pkg::alu_stat_t stat,
	output decc_pkg::result_t   res
);

	// Assembles one result beat from the captured operands and the unit's answer.
	always_comb begin
		res.status         = stat.status;
		res.first_operand  = opnd.first_operand;
		res.operator_char  = opnd.operator_char;
		res.second_operand = opnd.second_operand;
		res.result_value   = (stat.status == decc_pkg::ST_VALUE
			|| stat.status == decc_pkg::ST_OK) ? stat.value : 64'sd0;
	end

endmodule

### dv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// The block under test is built with its default character budget. The
	// predictor keeps its own copy of the same number.
	localparam int MAX_CHARS = 126;

	// Random expressions follow the directed ones until this many beats have
	// gone in overall.
	localparam int ITEM_BEATS = 950;

	// Nothing should sit still for long. The worst wait is a full sender gap,
	// a full receiver stall and a divide, so this many idle cycles in a row
	// with no beat on either channel means the block has hung.
	localparam int HANG_LIMIT = 2000;

	// After the last expected result, give a stray result time to show up.
	localparam int DRAIN_CYCLES = 200;

	// Operators that the block knows. Random expressions mostly use these.
	localparam logic [7:0] KNOWN_OPS [6] = '{decc_pkg::CH_PLUS, decc_pkg::CH_MINUS,
		decc_pkg::CH_STAR, decc_pkg::CH_X, decc_pkg::CH_SLASH, decc_pkg::CH_PCT};

	// Where the parser stands within one expression.
	typedef enum logic [2:0] {
		PH_FIRST_SIGN,
		PH_FIRST_DIGITS,
		PH_SECOND_SIGN,
		PH_SECOND_DIGITS,
		PH_DONE
	} parse_phase_t;

	// Mirrors the parser and the arithmetic of the block. Each character beat
	// advances the parser. Each end beat turns the parsed expression into the
	// result the block must return, and then clears the parser.
	class expression_checker;
		parse_phase_t phase;
		logic [63:0]  first_mag;
		logic [63:0]  second_mag;
		bit           first_neg;
		bit           second_neg;
		logic [7:0]   op_code;
		int           taken;

		decc_pkg::result_t awaited[$];
		int      errors;
		int      results_checked;
		int      char_beats;
		int      status_seen[5];

		function new();
			clear_expression();
		endfunction

		function void clear_expression();
			phase      = PH_FIRST_SIGN;
			first_mag  = '0;
			second_mag = '0;
			first_neg  = 1'b0;
			second_neg = 1'b0;
			op_code    = decc_pkg::CH_NONE;
			taken      = 0;
		endfunction

		function void note_beat(decc_pkg::item_t beat);
			logic [63:0] a, b, ma, mb, q, res, digit_val;
			logic [2:0]  st;
			bit          is_digit;
			decc_pkg::result_t want;
			if (beat.kind == decc_pkg::KIND_CHAR) begin
				char_beats++;
				// A NUL character does not count against the budget, and
				// anything past the budget is dropped.
				if (beat.character == decc_pkg::CH_NONE || taken >= MAX_CHARS)
					return;
				taken++;
				is_digit  = beat.character >= decc_pkg::CH_ZERO
					&& beat.character <= decc_pkg::CH_NINE;
				digit_val = 64'(beat.character - decc_pkg::CH_ZERO);
				case (phase)
					PH_FIRST_SIGN: begin
						if (beat.character == decc_pkg::CH_MINUS) begin
							first_neg = 1'b1;
							phase     = PH_FIRST_DIGITS;
						end else if (beat.character == decc_pkg::CH_PLUS) begin
							phase = PH_FIRST_DIGITS;
						end else if (is_digit) begin
							first_mag = digit_val;
							phase     = PH_FIRST_DIGITS;
						end else begin
							op_code = beat.character;
							phase   = PH_SECOND_SIGN;
						end
					end
					PH_FIRST_DIGITS: begin
						if (is_digit) begin
							first_mag = first_mag * 64'd10 + digit_val;
						end else begin
							op_code = beat.character;
							phase   = PH_SECOND_SIGN;
						end
					end
					PH_SECOND_SIGN: begin
						if (beat.character == decc_pkg::CH_MINUS) begin
							second_neg = 1'b1;
							phase      = PH_SECOND_DIGITS;
						end else if (beat.character == decc_pkg::CH_PLUS) begin
							phase = PH_SECOND_DIGITS;
						end else if (is_digit) begin
							second_mag = digit_val;
							phase      = PH_SECOND_DIGITS;
						end else begin
							phase = PH_DONE;
						end
					end
					PH_SECOND_DIGITS: begin
						if (is_digit)
							second_mag = second_mag * 64'd10 + digit_val;
						else
							phase = PH_DONE;
					end
					default: ;
				endcase
				return;
			end

			// End of the expression: apply the signs and do the arithmetic on
			// 64-bit two's complement values. Division works on magnitudes
			// and then restores the sign, which truncates toward zero.
			a = first_neg ? 64'd0 - first_mag : first_mag;
			if (op_code == decc_pkg::CH_NONE)
				b = '0;
			else
				b = second_neg ? 64'd0 - second_mag : second_mag;
			ma  = a[63] ? 64'd0 - a : a;
			mb  = b[63] ? 64'd0 - b : b;
			st  = decc_pkg::ST_OK;
			res = '0;
			if (op_code == decc_pkg::CH_NONE) begin
				st  = decc_pkg::ST_VALUE;
				res = a;
			end else begin
				case (op_code)
					decc_pkg::CH_PLUS:  res = a + b;
					decc_pkg::CH_MINUS: res = a - b;
					decc_pkg::CH_STAR, decc_pkg::CH_X: res = a * b;
					decc_pkg::CH_SLASH: begin
						if (b == '0) begin
							st = decc_pkg::ST_DIV0;
						end else begin
							q   = ma / mb;
							res = (a[63] ^ b[63]) ? 64'd0 - q : q;
						end
					end
					decc_pkg::CH_PCT: begin
						if (b == '0) begin
							st = decc_pkg::ST_MOD0;
						end else begin
							q   = ma % mb;
							res = a[63] ? 64'd0 - q : q;
						end
					end
					default: st = decc_pkg::ST_BADOP;
				endcase
			end
			want.status         = st;
			want.first_operand  = a;
			want.operator_char  = op_code;
			want.second_operand = b;
			want.result_value   = res;
			awaited.push_back(want);
			clear_expression();
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(decc_pkg::result_t got);
			decc_pkg::result_t want;
			if (awaited.size() == 0) begin
				$error("result beat with no expression pending: status %0d, value %0d",
					got.status, got.result_value);
				errors++;
				return;
			end
			want = awaited.pop_front();
			results_checked++;
			status_seen[want.status]++;
			compare_field("status", want.status, got.status);
			compare_field("first_operand", want.first_operand, got.first_operand);
			compare_field("operator_char", want.operator_char, got.operator_char);
			compare_field("second_operand", want.second_operand, got.second_operand);
			compare_field("result_value", want.result_value, got.result_value);
		endfunction
	endclass

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	decc_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b1;
	decc_pkg::result_t result;

	expression_checker book;
	int beats_sent;
	int sender_calm;
	int receiver_calm;
	int idle_cycles;

	always #6 clk = ~clk;

	decimal_expression_calculator #(
		.MAX_CHARS(MAX_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Both sides draw a random wait before each beat. Now and then a side
	// goes calm for a stretch of beats with no wait at all, so that
	// back-to-back traffic is covered as well.
	function automatic int draw_gap(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	// Offers one beat and returns at the edge where it is taken. Valid only
	// drops when a gap is drawn, so a run of zero gaps keeps it high.
	task automatic send_beat(input logic kind, input logic [7:0] ch);
		int gap;
		gap = draw_gap(sender_calm);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid     <= 1'b1;
		item.kind      <= kind;
		item.character <= ch;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_beat(decc_pkg::KIND_CHAR, text[i]);
	endtask

	task automatic send_expression(input string text);
		send_text(text);
		send_beat(decc_pkg::KIND_END, decc_pkg::CH_NONE);
	endtask

	task automatic send_digits(input int count, input bit zeros_only);
		repeat (count)
			send_beat(decc_pkg::KIND_CHAR, zeros_only ? decc_pkg::CH_ZERO
				: decc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_sign();
		case ($urandom_range(0, 3))
			0: send_beat(decc_pkg::KIND_CHAR, decc_pkg::CH_MINUS);
			1: send_beat(decc_pkg::KIND_CHAR, decc_pkg::CH_PLUS);
			default: ;
		endcase
	endtask

	// Most numbers are short. A few run past nineteen digits so that the
	// magnitude wraps, and a few are empty.
	function automatic int draw_digit_count();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return 0;
		if (pick < 88)
			return $urandom_range(1, 4);
		return $urandom_range(15, 21);
	endfunction

	// One random expression and its end beat. Most are well formed, with a
	// random sign, operands and a known operator; the rest are junk bytes, an
	// unknown operator, trailing characters, or a long expression that can run
	// past the character budget.
	task automatic send_random_expression();
		int shape;
		logic [7:0] op;
		shape = $urandom_range(0, 199);
		if (shape == 0) begin
			send_digits($urandom_range(40, 70), 1'b0);
			send_beat(decc_pkg::KIND_CHAR, KNOWN_OPS[$urandom_range(0, 5)]);
			send_digits($urandom_range(70, 90), 1'b0);
		end else if (shape < 25) begin
			repeat ($urandom_range(0, 6))
				send_beat(decc_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
		end else begin
			send_sign();
			send_digits(draw_digit_count(), 1'b0);
			if ($urandom_range(0, 9) == 0)
				send_beat(decc_pkg::KIND_CHAR, decc_pkg::CH_NONE);
			if ($urandom_range(0, 9) != 0) begin
				if ($urandom_range(0, 9) == 0)
					op = 8'($urandom_range(1, 255));
				else
					op = KNOWN_OPS[$urandom_range(0, 5)];
				send_beat(decc_pkg::KIND_CHAR, op);
				send_sign();
				// Some divisors are all zeros to hit the zero-divisor path.
				send_digits(draw_digit_count(), $urandom_range(0, 9) == 0);
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
					send_beat(decc_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
			end
		end
		send_beat(decc_pkg::KIND_END, decc_pkg::CH_NONE);
	endtask

	// Every beat is seen here, at the edge where it is accepted. Inputs are
	// driven by nonblocking assignments, so the values read here are the ones
	// the block itself samples at this edge. The same block watches for a hang.
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				book.note_beat(item);
				moved = 1'b1;
			end
			if (result_valid && !result_stall) begin
				book.check_result(result);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("decimal_expression_calculator regression: fail");
				$finish;
			end
		end
	end

	// Result side: stall for a drawn number of cycles, then take the next
	// result beat. Stall is assigned once per edge at most.
	initial begin
		int hold;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			hold = draw_gap(receiver_calm);
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
		end
	end

	initial begin
		book = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed expressions: an empty one, a bare value, each operator
		// with both signs, zero divisors, an unknown operator, the most
		// negative value over minus one, wrap of sums and of long digit
		// runs, NUL characters and the character budget.
		send_expression("");
		send_expression("-42");
		send_expression("*7");
		send_expression("-+3");
		send_expression("12+-30");
		send_expression("100-7");
		send_expression("-6*7");
		send_expression("9x-9");
		send_expression("-7/2");
		send_expression("7/-2");
		send_expression("-7%2");
		send_expression("7%-2");
		send_expression("5/0");
		send_expression("5%");
		send_expression("3a4");
		send_expression("-9223372036854775808/-1");
		send_expression("-9223372036854775808%-1");
		send_expression("9223372036854775807+1");
		send_expression("99999999999999999999999*3");
		send_expression("4*5=20");

		// A NUL between the digits is skipped, and a byte with every bit
		// set is an unknown operator.
		send_text("1");
		send_beat(decc_pkg::KIND_CHAR, decc_pkg::CH_NONE);
		send_expression("2+2");
		send_text("2");
		send_beat(decc_pkg::KIND_CHAR, 8'hFF);
		send_expression("3");

		// Past the budget: the NUL in the middle does not count, and the
		// digits after character 126 must not change the second number.
		send_text("5*");
		send_digits(60, 1'b0);
		send_beat(decc_pkg::KIND_CHAR, decc_pkg::CH_NONE);
		send_digits(70, 1'b0);
		send_beat(decc_pkg::KIND_END, decc_pkg::CH_NONE);

		while (beats_sent < ITEM_BEATS)
			send_random_expression();
		item_valid <= 1'b0;

		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d expressions over %0d character beats.",
			book.results_checked, book.char_beats);
		$display("Results by status: value %0d, ok %0d, div0 %0d, mod0 %0d, bad op %0d.",
			book.status_seen[decc_pkg::ST_VALUE], book.status_seen[decc_pkg::ST_OK],
			book.status_seen[decc_pkg::ST_DIV0], book.status_seen[decc_pkg::ST_MOD0],
			book.status_seen[decc_pkg::ST_BADOP]);
		if (book.errors == 0 && book.awaited.size() == 0)
			$display("decimal_expression_calculator regression: pass");
		else
			$display("decimal_expression_calculator regression: fail");
		$finish;
	end

endmodule
